// ===== sv/ttb_pkg.sv =====
// Shared types, widths and helpers for the triangle tangent/bitangent block.
package ttb_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int OUT_FRAC_BITS = 14;
   localparam int DIFF_W        = COORD_WIDTH + 1;
   localparam int PROD_W        = 2 * DIFF_W;
   localparam int SUM_W         = PROD_W + 1;
   localparam int MANT_W        = 24;
   localparam int LEN_W         = 2 * MANT_W + 2;
   localparam int SQ_W          = 64;
   localparam int ROOT_W        = 31;
   localparam int NUM_W         = OUT_FRAC_BITS + 31;
   localparam int DCNT_W        = $clog2(NUM_W);
   localparam int RES_W         = 16;
   localparam int PROD_COUNT    = 14;
   localparam int FIFO_DEPTH    = 2;
   localparam int PTR_W         = $clog2(FIFO_DEPTH);
   localparam int CNT_W         = PTR_W + 1;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
   } req_type;

   typedef struct packed {
      logic signed [RES_W-1:0] tangent_x;
      logic signed [RES_W-1:0] tangent_y;
      logic signed [RES_W-1:0] tangent_z;
      logic signed [RES_W-1:0] bitangent_x;
      logic signed [RES_W-1:0] bitangent_y;
      logic signed [RES_W-1:0] bitangent_z;
      logic                    degenerate;
   } rsp_type;

   // edges and uv deltas of one triangle
   typedef struct packed {
      logic signed [DIFF_W-1:0] e1_x;
      logic signed [DIFF_W-1:0] e1_y;
      logic signed [DIFF_W-1:0] e1_z;
      logic signed [DIFF_W-1:0] e2_x;
      logic signed [DIFF_W-1:0] e2_y;
      logic signed [DIFF_W-1:0] e2_z;
      logic signed [DIFF_W-1:0] du1;
      logic signed [DIFF_W-1:0] dv1;
      logic signed [DIFF_W-1:0] du2;
      logic signed [DIFF_W-1:0] dv2;
   } tri_type;

   typedef enum logic [3:0] {
      B_IDLE, B_PROD, B_CHECK, B_LOAD, B_SHIFT, B_LEN, B_SQRT,
      B_DSET, B_DIV, B_DFIN, B_DONE
   } back_state_type;

   function automatic logic signed [DIFF_W-1:0] coord_ext(input logic [31:0] raw);
      return {raw[COORD_WIDTH-1], raw[COORD_WIDTH-1:0]};
   endfunction

endpackage

// ===== sv/triangle_tangent_bitangent.sv =====
// Vertices go in one per request, three per triangle; the front end takes a vertex every
// cycle unless a third corner meets a full queue, and forms edges and uv deltas, queuing
// up to two triangles. The back end then works one triangle at a time: 14 products on one
// multiplier, then per vector a scaling pass, the sum of three squares, a square root and
// three divisions, all on one shared root and one shared divider. A zero determinant or a
// zero vector returns all-zero vectors with degenerate set.
module triangle_tangent_bitangent import ttb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic    push, queue_full, pop, empty;
   tri_type push_data, pop_data;

   ttb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   ttb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   ttb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

// ===== sv/ttb_front.sv =====
// Front end: holds the first two corners and forms edges and uv deltas.
module ttb_front import ttb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    push,
   output tri_type push_data,
   input  logic    queue_full
);

   logic [1:0]  corner_ff, corner_in;
   logic [31:0] pos_ff [2][3];
   logic [31:0] tex_ff [2][2];
   logic        third, accept;

   assign third     = corner_ff[1];
   assign req_stall = third & queue_full;
   assign accept    = req_valid & ~req_stall;
   assign push      = accept & third;

   always_comb begin
      corner_in = corner_ff;
      if (accept) begin
         if (third) corner_in = 2'd0;
         else corner_in = corner_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) corner_ff <= 2'd0;
      else corner_ff <= corner_in;
   end

   always_ff @(posedge clock) begin
      if (accept && !third) begin
         pos_ff[corner_ff[0]][0] <= req.pos_x;
         pos_ff[corner_ff[0]][1] <= req.pos_y;
         pos_ff[corner_ff[0]][2] <= req.pos_z;
         tex_ff[corner_ff[0]][0] <= req.tex_u;
         tex_ff[corner_ff[0]][1] <= req.tex_v;
      end
   end

   always_comb begin
      push_data.e1_x = coord_ext(pos_ff[1][0]) - coord_ext(pos_ff[0][0]);
      push_data.e1_y = coord_ext(pos_ff[1][1]) - coord_ext(pos_ff[0][1]);
      push_data.e1_z = coord_ext(pos_ff[1][2]) - coord_ext(pos_ff[0][2]);
      push_data.e2_x = coord_ext(req.pos_x) - coord_ext(pos_ff[0][0]);
      push_data.e2_y = coord_ext(req.pos_y) - coord_ext(pos_ff[0][1]);
      push_data.e2_z = coord_ext(req.pos_z) - coord_ext(pos_ff[0][2]);
      push_data.du1  = coord_ext(tex_ff[1][0]) - coord_ext(tex_ff[0][0]);
      push_data.dv1  = coord_ext(tex_ff[1][1]) - coord_ext(tex_ff[0][1]);
      push_data.du2  = coord_ext(req.tex_u) - coord_ext(tex_ff[0][0]);
      push_data.dv2  = coord_ext(req.tex_v) - coord_ext(tex_ff[0][1]);
   end

endmodule

// ===== sv/ttb_queue.sv =====
// Short queue of triangles between front end and back end.
module ttb_queue import ttb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  tri_type push_data,
   output logic    full,
   input  logic    pop,
   output tri_type pop_data,
   output logic    empty
);

   tri_type          slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == CNT_W'(FIFO_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("queue pop while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");
`endif

endmodule

// ===== sv/ttb_back.sv =====
// Back end: cross products, normalisation with shared sqrt and divider.
module ttb_back import ttb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    empty,
   input  tri_type pop_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   back_state_type state_ff, state_in;

   logic signed [DIFF_W-1:0] e1_ff [3];
   logic signed [DIFF_W-1:0] e2_ff [3];
   logic signed [DIFF_W-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic [3:0]               pidx_ff;
   logic [2:0]               pair, pdest_ff;
   logic [1:0]               sel;
   logic signed [DIFF_W-1:0] opa, opb;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  prod_ext;
   logic                     pvalid_ff, pneg_ff;
   logic signed [SUM_W-1:0]  acc_ff, det_ff;
   logic signed [SUM_W-1:0]  tr_ff [3];
   logic signed [SUM_W-1:0]  br_ff [3];
   logic                     vec_ff, flip_ff, deg_ff;
   logic                     sg_ff [3];
   logic [SUM_W-1:0]         mag_ff [3];
   logic [SUM_W-1:0]         orall;
   logic                     vec_zero, in_range;
   logic [1:0]               k_ff;
   logic [LEN_W-1:0]         len_ff, len_sum;
   logic [SQ_W-1:0]          sq_v_ff, sq_r_ff, sq_b_ff, sq_t;
   logic [NUM_W-1:0]         num_ff, quo_ff, quo_clamp;
   logic [ROOT_W:0]          rem_ff;
   logic [ROOT_W+1:0]        rem2, rem_diff;
   logic                     ge;
   logic [DCNT_W-1:0]        dcnt_ff;
   logic [RES_W-1:0]         res_val;
   logic signed [RES_W-1:0]  tan_ff [3];
   logic signed [RES_W-1:0]  bit_ff [3];
   logic                     rsp_valid_ff, rsp_load;
   rsp_type                  rsp_ff;

   // product schedule: det, then tangent x/y/z, then bitangent x/y/z
   assign pair = pidx_ff[3:1];
   assign sel  = (pair < 3'd4) ? 2'(pair - 3'd1) : 2'(pair - 3'd4);

   always_comb begin
      opa = '0;
      opb = '0;
      unique case (pair)
         3'd0: begin
            opa = pidx_ff[0] ? du2_ff : du1_ff;
            opb = pidx_ff[0] ? dv1_ff : dv2_ff;
         end
         3'd1, 3'd2, 3'd3: begin
            opa = pidx_ff[0] ? dv2_ff : dv1_ff;
            opb = pidx_ff[0] ? e1_ff[sel] : e2_ff[sel];
         end
         3'd4, 3'd5, 3'd6: begin
            opa = pidx_ff[0] ? du1_ff : du2_ff;
            opb = pidx_ff[0] ? e2_ff[sel] : e1_ff[sel];
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign prod_ext = {prod_ff[PROD_W-1], prod_ff};

   always_comb begin
      orall    = mag_ff[0] | mag_ff[1] | mag_ff[2];
      in_range = ~|orall[SUM_W-1:MANT_W] & orall[MANT_W-1];
      vec_zero = vec_ff ? (br_ff[0] == '0 && br_ff[1] == '0 && br_ff[2] == '0)
                        : (tr_ff[0] == '0 && tr_ff[1] == '0 && tr_ff[2] == '0);
      len_sum  = len_ff + LEN_W'(mag_ff[k_ff][MANT_W-1:0] * mag_ff[k_ff][MANT_W-1:0]);
      sq_t     = sq_r_ff + sq_b_ff;
      rem2     = {rem_ff, num_ff[NUM_W-1]};
      rem_diff = rem2 - (ROOT_W+2)'(sq_r_ff[ROOT_W-1:0]);
      ge       = rem2 >= (ROOT_W+2)'(sq_r_ff[ROOT_W-1:0]);
      quo_clamp = (quo_ff > (NUM_W'(1) << OUT_FRAC_BITS)) ?
                  (NUM_W'(1) << OUT_FRAC_BITS) : quo_ff;
      res_val  = (sg_ff[k_ff] ^ flip_ff) ? RES_W'(-quo_clamp) : quo_clamp[RES_W-1:0];
   end

   // control outputs
   always_comb begin
      pop      = (state_ff == B_IDLE) && !empty;
      rsp_load = (state_ff == B_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (pop) state_in = B_PROD;
         B_PROD:  if (pidx_ff == 4'(PROD_COUNT)) state_in = B_CHECK;
         B_CHECK: state_in = (det_ff == '0) ? B_DONE : B_LOAD;
         B_LOAD:  state_in = vec_zero ? B_DONE : B_SHIFT;
         B_SHIFT: if (in_range) state_in = B_LEN;
         B_LEN:   if (k_ff == 2'd2) state_in = B_SQRT;
         B_SQRT:  if (sq_b_ff == '0) state_in = B_DSET;
         B_DSET:  state_in = B_DIV;
         B_DIV:   if (dcnt_ff == DCNT_W'(NUM_W - 1)) state_in = B_DFIN;
         B_DFIN: begin
            if (k_ff != 2'd2) state_in = B_DSET;
            else if (!vec_ff) state_in = B_LOAD;
            else state_in = B_DONE;
         end
         B_DONE:  if (rsp_load) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pvalid_ff <= (state_ff == B_PROD) && (pidx_ff < 4'(PROD_COUNT));
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pvalid_ff) begin
         if (!pneg_ff) begin
            acc_ff <= prod_ext;
         end else if (pdest_ff == 3'd0) begin
            det_ff <= acc_ff - prod_ext;
         end else if (pdest_ff < 3'd4) begin
            tr_ff[2'(pdest_ff - 3'd1)] <= acc_ff - prod_ext;
         end else begin
            br_ff[2'(pdest_ff - 3'd4)] <= acc_ff - prod_ext;
         end
      end
      unique case (state_ff)
         B_IDLE: begin
            e1_ff[0] <= pop_data.e1_x;
            e1_ff[1] <= pop_data.e1_y;
            e1_ff[2] <= pop_data.e1_z;
            e2_ff[0] <= pop_data.e2_x;
            e2_ff[1] <= pop_data.e2_y;
            e2_ff[2] <= pop_data.e2_z;
            du1_ff   <= pop_data.du1;
            dv1_ff   <= pop_data.dv1;
            du2_ff   <= pop_data.du2;
            dv2_ff   <= pop_data.dv2;
            pidx_ff  <= '0;
            deg_ff   <= 1'b0;
         end
         B_PROD: begin
            prod_ff  <= opa * opb;
            pneg_ff  <= pidx_ff[0];
            pdest_ff <= pair;
            pidx_ff  <= pidx_ff + 4'd1;
         end
         B_CHECK: begin
            flip_ff <= ~det_ff[SUM_W-1];
            vec_ff  <= 1'b0;
            if (det_ff == '0) deg_ff <= 1'b1;
         end
         B_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               sg_ff[i]  <= vec_ff ? br_ff[i][SUM_W-1] : tr_ff[i][SUM_W-1];
               mag_ff[i] <= vec_ff ? (br_ff[i][SUM_W-1] ? -br_ff[i] : br_ff[i])
                                   : (tr_ff[i][SUM_W-1] ? -tr_ff[i] : tr_ff[i]);
            end
            if (vec_zero) deg_ff <= 1'b1;
         end
         B_SHIFT: begin
            // coarse steps of eight, fine steps of one; floors compose exactly
            for (int i = 0; i < 3; i++) begin
               if (|orall[SUM_W-1:32]) mag_ff[i] <= mag_ff[i] >> 8;
               else if (|orall[SUM_W-1:MANT_W]) mag_ff[i] <= mag_ff[i] >> 1;
               else if (~|orall[MANT_W-1:15]) mag_ff[i] <= mag_ff[i] << 8;
               else if (!orall[MANT_W-1]) mag_ff[i] <= mag_ff[i] << 1;
            end
            len_ff <= '0;
            k_ff   <= '0;
         end
         B_LEN: begin
            len_ff  <= len_sum;
            k_ff    <= k_ff + 2'd1;
            sq_v_ff <= SQ_W'(len_sum) << 12;
            sq_r_ff <= '0;
            sq_b_ff <= SQ_W'(1) << 62;
         end
         B_SQRT: begin
            if (sq_b_ff != '0) begin
               if (sq_v_ff >= sq_t) begin
                  sq_v_ff <= sq_v_ff - sq_t;
                  sq_r_ff <= (sq_r_ff >> 1) + sq_b_ff;
               end else begin
                  sq_r_ff <= sq_r_ff >> 1;
               end
               sq_b_ff <= sq_b_ff >> 2;
            end
            k_ff <= '0;
         end
         B_DSET: begin
            num_ff  <= (NUM_W'(mag_ff[k_ff][MANT_W-1:0]) << (OUT_FRAC_BITS + 6))
                       + NUM_W'(sq_r_ff[ROOT_W-1:1]);
            rem_ff  <= '0;
            quo_ff  <= '0;
            dcnt_ff <= '0;
         end
         B_DIV: begin
            rem_ff  <= ge ? rem_diff[ROOT_W:0] : rem2[ROOT_W:0];
            num_ff  <= num_ff << 1;
            quo_ff  <= {quo_ff[NUM_W-2:0], ge};
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         B_DFIN: begin
            if (vec_ff) bit_ff[k_ff] <= res_val;
            else tan_ff[k_ff] <= res_val;
            k_ff <= k_ff + 2'd1;
            if (k_ff == 2'd2) vec_ff <= 1'b1;
         end
         B_DONE: begin
            if (rsp_load) begin
               rsp_ff.tangent_x   <= deg_ff ? '0 : tan_ff[0];
               rsp_ff.tangent_y   <= deg_ff ? '0 : tan_ff[1];
               rsp_ff.tangent_z   <= deg_ff ? '0 : tan_ff[2];
               rsp_ff.bitangent_x <= deg_ff ? '0 : bit_ff[0];
               rsp_ff.bitangent_y <= deg_ff ? '0 : bit_ff[1];
               rsp_ff.bitangent_z <= deg_ff ? '0 : bit_ff[2];
               rsp_ff.degenerate  <= deg_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== sim/tb_triangle_tangent_bitangent.sv =====
// Self-checking testbench for the triangle tangent/bitangent block.
module tb_triangle_tangent_bitangent;
   timeunit 1ns;
   timeprecision 1ps;
   import ttb_pkg::*;

   localparam int N_RANDOM    = 1750;
   localparam int WDOG_LIMIT  = 20000;
   localparam int HOLD_CYCLES = 2500;
   localparam int DRAIN       = 1000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   triangle_tangent_bitangent dut (.*);

   always #1 clock = ~clock;

   // directed table: three vertices per triangle
   localparam int N_DIR = 18;
   req_type dir_vert[N_DIR];
   bit      dir_typed[N_DIR];
   rsp_type dir_rsp[N_DIR];

   // predictor state
   logic [31:0] held_pos[6];
   logic [31:0] held_tex[4];
   int          corners_held = 0;

   rsp_type tangents_due[$];
   int      n_req_accepted = 0;
   int      n_rsp_checked = 0;
   int      n_degenerate = 0;
   int      n_errors = 0;
   int      idle_cycles = 0;
   bit      quiet = 1'b0;

   function automatic logic signed [127:0] coord_of(input logic [31:0] raw);
      logic signed [127:0] v;
      v = $signed(raw);
      v = (v <<< (128 - COORD_WIDTH)) >>> (128 - COORD_WIDTH);
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // unit vector in Q(OUT_FRAC_BITS), negated when flip; 0 when the vector is zero
   function automatic bit to_unit(input logic signed [127:0] c0, c1, c2, input bit flip,
                                  output logic [2:0][15:0] o);
      logic signed [127:0] c[3];
      logic [127:0]        mag[3];
      bit                  neg[3];
      longint unsigned     m[3], len, r, q, one;
      int                  b;
      c[0] = c0; c[1] = c1; c[2] = c2;
      b = 0;
      len = 0;
      one = 64'd1 << OUT_FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         neg[i] = c[i] < 0;
         mag[i] = neg[i] ? -c[i] : c[i];
         for (int k = 0; k < 128; k++)
            if (mag[i][k] && k + 1 > b) b = k + 1;
      end
      if (b == 0) return 1'b0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (b > 24) ? 64'(mag[i] >> (b - 24)) : 64'(mag[i] << (24 - b));
         len += m[i] * m[i];
      end
      r = int_sqrt(len << 12);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << (OUT_FRAC_BITS + 6)) + (r >> 1)) / r;
         if (q > one) q = one;
         o[i] = (neg[i] != flip) ? 16'(-q) : 16'(q);
      end
      return 1'b1;
   endfunction

   // one vertex into the predictor; returns 1 with the result on a closing corner
   function automatic bit predict_vertex(input req_type v, output rsp_type exp);
      logic signed [127:0] p[3][3], t[3][2], e1[3], e2[3], du1, dv1, du2, dv2, det;
      logic [2:0][15:0]    tv, bv;
      bit                  ok;
      int                  s;
      exp = '0;
      if (corners_held < 2) begin
         s = corners_held;
         held_pos[s*3] = v.pos_x; held_pos[s*3+1] = v.pos_y; held_pos[s*3+2] = v.pos_z;
         held_tex[s*2] = v.tex_u; held_tex[s*2+1] = v.tex_v;
         corners_held = s + 1;
         return 1'b0;
      end
      corners_held = 0;
      for (int j = 0; j < 2; j++) begin
         for (int i = 0; i < 3; i++) p[j][i] = coord_of(held_pos[j*3+i]);
         t[j][0] = coord_of(held_tex[j*2]);
         t[j][1] = coord_of(held_tex[j*2+1]);
      end
      p[2][0] = coord_of(v.pos_x); p[2][1] = coord_of(v.pos_y); p[2][2] = coord_of(v.pos_z);
      t[2][0] = coord_of(v.tex_u); t[2][1] = coord_of(v.tex_v);
      for (int i = 0; i < 3; i++) begin
         e1[i] = p[1][i] - p[0][i];
         e2[i] = p[2][i] - p[0][i];
      end
      du1 = t[1][0] - t[0][0]; dv1 = t[1][1] - t[0][1];
      du2 = t[2][0] - t[0][0]; dv2 = t[2][1] - t[0][1];
      det = du1 * dv2 - du2 * dv1;
      ok = det != 0;
      if (ok) ok = to_unit(dv1*e2[0] - dv2*e1[0], dv1*e2[1] - dv2*e1[1],
                           dv1*e2[2] - dv2*e1[2], det >= 0, tv);
      if (ok) ok = to_unit(du2*e1[0] - du1*e2[0], du2*e1[1] - du1*e2[1],
                           du2*e1[2] - du1*e2[2], det >= 0, bv);
      if (ok) begin
         exp.tangent_x = tv[0]; exp.tangent_y = tv[1]; exp.tangent_z = tv[2];
         exp.bitangent_x = bv[0]; exp.bitangent_y = bv[1]; exp.bitangent_z = bv[2];
      end
      exp.degenerate = !ok;
      return 1'b1;
   endfunction

   function automatic req_type vtx(input logic [31:0] x, y, z, u, v);
      req_type r;
      r.pos_x = x; r.pos_y = y; r.pos_z = z; r.tex_u = u; r.tex_v = v;
      return r;
   endfunction

   function automatic logic [31:0] rand_coord(input int kind);
      unique case (kind)
         0:       return $urandom;
         1:       return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
         2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(32'h0000_0100)) - 32'sh80);
      endcase
   endfunction

   initial begin
      rsp_type unit_x, deg;
      deg = '0; deg.degenerate = 1'b1;
      unit_x = '0; unit_x.tangent_x = 16'sd16384; unit_x.bitangent_y = 16'sd16384;
      foreach (dir_typed[i]) begin
         dir_typed[i] = 1'b0;
         dir_rsp[i] = '0;
      end
      // all-zero triangle: zero determinant
      dir_vert[0] = vtx(0, 0, 0, 0, 0);
      dir_vert[1] = vtx(0, 0, 0, 0, 0);
      dir_vert[2] = vtx(0, 0, 0, 0, 0);
      dir_typed[2] = 1'b1; dir_rsp[2] = deg;
      // axis-aligned unit triangle
      dir_vert[3] = vtx(0, 0, 0, 0, 0);
      dir_vert[4] = vtx(32'h0001_0000, 0, 0, 32'h0001_0000, 0);
      dir_vert[5] = vtx(0, 32'h0001_0000, 0, 0, 32'h0001_0000);
      dir_typed[5] = 1'b1; dir_rsp[5] = unit_x;
      // extreme positions, flat uv: degenerate
      dir_vert[6] = vtx(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 5, 5);
      dir_vert[7] = vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 5, 5);
      dir_vert[8] = vtx(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 5, 5);
      dir_typed[8] = 1'b1; dir_rsp[8] = deg;
      // extreme positions and extreme uvs
      dir_vert[9]  = vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000);
      dir_vert[10] = vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h8000_0000);
      dir_vert[11] = vtx(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF);
      // coincident positions, good uv: zero tangent
      dir_vert[12] = vtx(7, 7, 7, 0, 0);
      dir_vert[13] = vtx(7, 7, 7, 32'h0001_0000, 0);
      dir_vert[14] = vtx(7, 7, 7, 0, 32'h0001_0000);
      dir_typed[14] = 1'b1; dir_rsp[14] = deg;
      // tiny vectors, negative determinant
      dir_vert[15] = vtx(0, 0, 0, 0, 0);
      dir_vert[16] = vtx(0, 1, 0, 0, 1);
      dir_vert[17] = vtx(1, 0, 1, 1, 0);
   end

   task automatic check_field(input string fname, input int exp, input int act);
      if (exp != act) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, fname, exp, act);
         n_errors++;
      end
   endtask

   // request side: predict; result side: compare with the oldest expectation
   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && req_valid && !req_stall) begin
         if (predict_vertex(req, exp)) begin
            if (n_req_accepted < N_DIR && dir_typed[n_req_accepted])
               exp = dir_rsp[n_req_accepted];
            tangents_due = {tangents_due, exp};
         end
         n_req_accepted++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tangents_due.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, rsp);
            n_errors++;
         end else begin
            exp = tangents_due.pop_front();
            check_field("tangent_x", exp.tangent_x, rsp.tangent_x);
            check_field("tangent_y", exp.tangent_y, rsp.tangent_y);
            check_field("tangent_z", exp.tangent_z, rsp.tangent_z);
            check_field("bitangent_x", exp.bitangent_x, rsp.bitangent_x);
            check_field("bitangent_y", exp.bitangent_y, rsp.bitangent_y);
            check_field("bitangent_z", exp.bitangent_z, rsp.bitangent_z);
            check_field("degenerate", exp.degenerate, rsp.degenerate);
            if (rsp.degenerate) n_degenerate++;
         end
         n_rsp_checked++;
      end
      if (!reset && !(req_valid && !req_stall) && !(rsp_valid && !rsp_stall))
         idle_cycles++;
      else
         idle_cycles = 0;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("watchdog: no request or result moved for %0d cycles", WDOG_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   // result side back-pressure, with one long hold-off so the block fills up
   initial begin
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (1) begin
         @(posedge clock);
         if (!held && n_req_accepted > 300) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 30);
      end
   end

   task automatic offer(input req_type v);
      if (!quiet && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req <= v;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      req_type          v;
      logic [31:0]      tu, tv;
      int               kind, shape;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < N_DIR; i++) offer(dir_vert[i]);
      for (int i = 0; i < N_RANDOM; i += 3) begin
         quiet = (i >= 800 && i < 1100);
         kind = $urandom_range(9) < 4 ? 0 : ($urandom_range(2) + 1);
         shape = $urandom_range(9);
         for (int c = 0; c < 3; c++) begin
            tu = rand_coord(kind);
            tv = rand_coord(kind);
            // flat or repeated uvs give a zero determinant
            if (shape == 0) tv = tu;
            if (shape == 1 && c > 0) tu = v.tex_u;
            v = vtx(rand_coord(kind), rand_coord(kind), rand_coord(kind), tu, tv);
            if (shape == 2 && c > 0) v.pos_y = 0;
            offer(v);
         end
      end
      req_valid <= 1'b0;
      quiet = 1'b0;
      wait (tangents_due.size() == 0);
      repeat (DRAIN) @(posedge clock);
      $display("%0d vertices in, %0d triangles checked, %0d degenerate",
               n_req_accepted, n_rsp_checked, n_degenerate);
      if (n_errors == 0 && tangents_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
